[design/tpsd_pkg.sv]
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the touch pad event and slide detector.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int unsigned TOUCH_W        = 12;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned WINDOW_W       = 16;
  localparam int unsigned PAD_IDX_W      = 4;
  localparam int unsigned NUM_PADS_DEF   = 12;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(200);

  // register index, taken from paddr[2]
  localparam logic REG_SLIDE_WINDOW = 1'b0;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_LEFT  = 2'd2
  } event_kind_e;

endpackage

[design/tpsd_if.sv]
// ----------------------------------------------------------------------------
// tpsd channels
// Valid/ready channels for touch samples in and pad or slide events out.
// ----------------------------------------------------------------------------
interface tpsd_sample_if import tpsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TOUCH_W-1:0]   touch_bits;
  logic [TIME_W-1:0]    time_ms;

  modport source (output valid, output touch_bits, output time_ms, input ready);
  modport sink   (input valid, input touch_bits, input time_ms, output ready);
endinterface

interface tpsd_event_if import tpsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_kind;
  logic [PAD_IDX_W-1:0] pad_index;
  logic                 pressed;
  logic                 last_of_run;

  modport source (output valid, output event_kind, output pad_index, output pressed,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input pad_index, input pressed,
                  input last_of_run, output ready);
endinterface

[design/touch_pad_event_and_slide_detector.sv]
// ----------------------------------------------------------------------------
// touch_pad_event_and_slide_detector
// Turns touch pad samples into pad press/release events and slide gestures.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one touch bitmap plus a millisecond timestamp per
//   transfer. event_o carries the resulting events, one per transfer:
//   an optional slide press/release pair first, then one key event per
//   changed pad in ascending order; last_of_run marks the final event of
//   a sample. A sample that changes nothing produces no event.
//   The APB port holds slide_window_ms at address 0 (reset 200).
// Timing:
//   the slide decision and change mask are computed when a sample is taken,
//   stored in the sequencer registers and passed from there, one event at a
//   time, to the output register. The sequencer emits one event per cycle
//   while event_o is not held off; a sample has at most 2 + pad count events
//   (14 for twelve pads). The next sample is taken in the cycle the current
//   one issues its last event, so single-event samples stream every cycle unless stalled.
// Reset: no pads touched, no slide in progress, window back to 200 ms.
// Stall: while event_o is held off, the output register keeps its event,
//   the sequencer waits, and sample_i.ready drops once it has work queued.
// ----------------------------------------------------------------------------
module touch_pad_event_and_slide_detector import tpsd_pkg::*; #(
  parameter int unsigned NUM_PADS = NUM_PADS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  tpsd_sample_if.sink            sample_i,
  tpsd_event_if.source           event_o
);

  localparam int unsigned NumLive = (NUM_PADS < TOUCH_W) ? NUM_PADS : TOUCH_W;

  function automatic logic [PAD_IDX_W-1:0] highest_pad(input logic [NumLive-1:0] v);
    logic [PAD_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NumLive; i++) begin
      if (v[i]) r = PAD_IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [PAD_IDX_W-1:0] lowest_pad(input logic [NumLive-1:0] v);
    logic [PAD_IDX_W-1:0] r;
    r = '0;
    for (int i = NumLive - 1; i >= 0; i--) begin
      if (v[i]) r = PAD_IDX_W'(i);
    end
    return r;
  endfunction

  // configuration
  logic [WINDOW_W-1:0] window_q;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SLIDE_WINDOW);
  assign prdata  = reg_sel ? APB_DATA_W'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      window_q <= pwdata[WINDOW_W-1:0];
    end
  end

  // detector state
  logic [NumLive-1:0]   prev_touch_q;
  logic                 slide_active_q;
  logic [PAD_IDX_W-1:0] start_pad_q;
  logic [TIME_W-1:0]    start_time_q;

  // event sequencer: pending slide events and remaining changed pads
  logic [1:0]           slide_cnt_q, slide_cnt_d;
  event_kind_e          slide_kind_q, slide_kind_d;
  logic [NumLive-1:0]   chg_q, chg_d;

  // output register
  logic                 out_valid_q;
  event_kind_e          out_kind_q;
  logic [PAD_IDX_W-1:0] out_pad_q;
  logic                 out_pressed_q;
  logic                 out_last_q;

  logic in_fire, out_fire, out_free, busy, emit;

  // sample evaluation
  logic [NumLive-1:0]   touched, changed;
  logic                 any_touch, in_window, slide_fire, slide_start;
  logic [PAD_IDX_W-1:0] hi_pad;
  logic [TIME_W-1:0]    elapsed;

  assign touched     = sample_i.touch_bits[NumLive-1:0];
  assign changed     = touched ^ prev_touch_q;
  assign any_touch   = |touched;
  assign hi_pad      = highest_pad(touched);
  assign elapsed     = sample_i.time_ms - start_time_q;
  assign in_window   = elapsed < TIME_W'(window_q);
  assign slide_fire  = slide_active_q && any_touch && in_window && (hi_pad != start_pad_q);
  assign slide_start = !slide_active_q && (|changed) && any_touch;

  // next event from the sequencer
  logic [NumLive-1:0]   chg_low, chg_rest;
  event_kind_e          emit_kind;
  logic [PAD_IDX_W-1:0] emit_pad;
  logic                 emit_pressed, emit_last;

  assign chg_low  = chg_q & (~chg_q + NumLive'(1));
  assign chg_rest = chg_q & ~chg_low;

  always_comb begin
    if (slide_cnt_q != 2'd0) begin
      emit_kind    = slide_kind_q;
      emit_pad     = '0;
      emit_pressed = (slide_cnt_q == 2'd2);
      emit_last    = (slide_cnt_q == 2'd1) && (chg_q == '0);
    end else begin
      emit_kind    = KIND_KEY;
      emit_pad     = lowest_pad(chg_q);
      // prev_touch_q already holds this sample's bits
      emit_pressed = |(prev_touch_q & chg_low);
      emit_last    = (chg_rest == '0);
    end
  end

  assign busy     = (slide_cnt_q != 2'd0) || (chg_q != '0);
  assign out_free = !out_valid_q || event_o.ready;
  assign emit     = busy && out_free;

  assign sample_i.ready = !busy || (out_free && emit_last);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_fire       = event_o.valid && event_o.ready;

  always_comb begin
    slide_cnt_d  = slide_cnt_q;
    slide_kind_d = slide_kind_q;
    chg_d        = chg_q;
    if (emit) begin
      if (slide_cnt_q != 2'd0) begin
        slide_cnt_d = slide_cnt_q - 2'd1;
      end else begin
        chg_d = chg_rest;
      end
    end
    if (in_fire) begin
      slide_cnt_d  = slide_fire ? 2'd2 : 2'd0;
      slide_kind_d = (hi_pad > start_pad_q) ? KIND_RIGHT : KIND_LEFT;
      chg_d        = changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_touch_q   <= '0;
      slide_active_q <= 1'b0;
      start_pad_q    <= '0;
      start_time_q   <= '0;
      slide_cnt_q    <= 2'd0;
      slide_kind_q   <= KIND_RIGHT;
      chg_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      slide_cnt_q  <= slide_cnt_d;
      slide_kind_q <= slide_kind_d;
      chg_q        <= chg_d;
      if (in_fire) begin
        prev_touch_q <= touched;
        if (slide_start) begin
          slide_active_q <= 1'b1;
          start_pad_q    <= hi_pad;
          start_time_q   <= sample_i.time_ms;
        end else if (slide_fire || (slide_active_q && !any_touch)) begin
          slide_active_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q    <= emit_kind;
      out_pad_q     <= emit_pad;
      out_pressed_q <= emit_pressed;
      out_last_q    <= emit_last;
    end
  end

  assign event_o.valid       = out_valid_q;
  assign event_o.event_kind  = out_kind_q;
  assign event_o.pad_index   = out_pad_q;
  assign event_o.pressed     = out_pressed_q;
  assign event_o.last_of_run = out_last_q;

  // a slide only ends on a sample transfer
  a_slide_end_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(slide_active_q) |-> $past(in_fire))
    else $error("slide ended without a sample transfer");

  // a slide press never closes a run
  a_slide_press_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid && (event_o.event_kind != KIND_KEY) && event_o.pressed
      |-> !event_o.last_of_run)
    else $error("slide press flagged as last event");

  // a transferred slide press is followed at once by its release
  a_slide_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (event_o.event_kind != KIND_KEY) && event_o.pressed
      |=> event_o.valid && !event_o.pressed
          && (event_o.event_kind == $past(event_o.event_kind)))
    else $error("slide press not followed by its release");

  // key events only name live pads
  a_key_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid && (event_o.event_kind == KIND_KEY)
      |-> event_o.pad_index < PAD_IDX_W'(NumLive))
    else $error("key event pad index out of range");

endmodule
